// ===== sv/depth_to_time_trace_resampler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Depth-to-time resampler assertion macros
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_TIME_TRACE_RESAMPLER_TOP_MACROS_SVH
`define DEPTH_TO_TIME_TRACE_RESAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define DTTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTTR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dttr_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth-to-time resampler package
// Shared constants, codes and types of the resampler.
// ----------------------------------------------------------------------------
package dttr_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;

  localparam int VSUM_W = 28;
  localparam logic [VSUM_W-1:0] VSUM_MAX = {VSUM_W{1'b1}};
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
  localparam int MS_SCALE = 1000;

  // shared multiplier operand width
  localparam int MUL_W = 35;

  // shared divider widths
  localparam int DIVN_W = 68;
  localparam int DIVD_W = 33;
  localparam int DIVR_W = 34;
  localparam int ITER_W = 7;
  localparam logic [ITER_W-1:0] ITERS_LOAD = ITER_W'(32);
  localparam logic [ITER_W-1:0] ITERS_EMIT = ITER_W'(DIVN_W);

  typedef enum logic [2:0] {
    CFG_FIRST_DEPTH = 3'd0,
    CFG_DEPTH_STEP  = 3'd1,
    CFG_TIME_STEP   = 3'd2,
    CFG_OUT_COUNT   = 3'd3,
    CFG_NULL_VALUE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_L_M1,
    S_L_M2,
    S_L_M3,
    S_L_DIV,
    S_L_WAIT,
    S_E_X,
    S_E_RD0,
    S_E_CHK0,
    S_E_WALK,
    S_E_WCHK,
    S_E_RDA,
    S_E_RDB,
    S_E_CAPB,
    S_E_M0,
    S_E_M1,
    S_E_M2,
    S_E_WAIT,
    S_E_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== sv/dttr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dttr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dttr_div.sv =====
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle; remainder and numerator preloaded by caller.
// ----------------------------------------------------------------------------
module dttr_div import dttr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [DIVR_W-1:0] rem_init,
  input  logic [DIVN_W-1:0] num_init,
  input  logic [DIVD_W-1:0] den,
  output div_sts_t          sts,
  output logic [DIVN_W-1:0] quo,
  output logic [DIVR_W-1:0] rem
);

  logic [ITER_W-1:0] cnt_r;
  logic              done_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVN_W-1:0] qr_r;
  logic [DIVD_W-1:0] den_r;
  logic [DIVR_W-1:0] rs;
  logic [DIVR_W:0]   diff;

  assign rs   = {rem_r[DIVR_W-2:0], qr_r[DIVN_W-1]};
  assign diff = {1'b0, rs} - (DIVR_W+1)'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        cnt_r <= ctl.iters;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == ITER_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= rem_init;
      qr_r  <= num_init;
      den_r <= den;
    end else if (cnt_r != '0) begin
      // keep the trial difference when it does not go negative
      rem_r <= diff[DIVR_W] ? rs : diff[DIVR_W-1:0];
      qr_r  <= {qr_r[DIVN_W-2:0], ~diff[DIVR_W]};
    end
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign quo      = qr_r;
  assign rem      = rem_r;

endmodule

// ===== sv/depth_to_time_trace_resampler_top.sv =====
// ----------------------------------------------------------------------------
// Depth-to-time trace resampler
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+--------------------------------------
//   in      | in  | in_valid / in_ready   | in_operation, in_velocity,
//           |     |                       | in_sample_value
//   out     | out | out_valid / out_ready | out_value, out_index, out_trace_end
//   cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A load word makes three passes through the shared multiplier and 32 steps of
// the shared divider; a saturated time skips the divider.
// An emit word walks the stored segments; an interpolated result takes the
// 68 steps of the divider, and a fill result skips the divider.
// Time and value stores share one read address per cycle; no clearing pass.
// Reset is synchronous, active low; a full output register stalls only emits.
// ----------------------------------------------------------------------------
module depth_to_time_trace_resampler_top import dttr_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_velocity,
  input  logic [31:0] in_sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic [15:0] out_index,
  output logic        out_trace_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  state_t state_r, state_nxt;

  logic [15:0]       fd_r, ts_r, oc_r;
  logic [9:0]        ds_r;
  logic [31:0]       nv_r;
  logic [VSUM_W-1:0] vsum_r;
  logic [CW-1:0]     cnt_r;
  logic [AW-1:0]     seg_r;
  logic [15:0]       oidx_r;
  logic              last_r;
  logic [31:0]       samp_r;
  logic [31:0]       x_r, t0_r, t1_r, v0_r, v1_r;
  logic [26:0]       z_r;
  logic [66:0]       acc_r;
  logic signed [69:0] prod_r;
  logic [31:0]       res_r;
  logic              out_valid_r, out_end_r;
  logic [31:0]       out_value_r;
  logic [15:0]       out_index_r;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [69:0]      mul_p;

  logic [AW-1:0]  raddr;
  logic [31:0]    rt, rv;
  logic           we;
  logic [31:0]    wtime;

  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [DIVR_W-1:0] div_rem_init;
  logic [DIVN_W-1:0] div_num;
  logic [DIVD_W-1:0] div_den;
  logic [DIVN_W-1:0] div_quo;
  logic [DIVR_W-1:0] div_rem;

  logic              accept, fire, seg_inc, res_we;
  logic [31:0]       res_val;
  logic              tsat;
  logic [62:0]       num63;
  logic [CW-1:0]     seg_nx;
  logic [66:0]       sum67;
  logic [67:0]       n68;
  logic              neg_r;
  logic [31:0]       qlow;
  logic [31:0]       dlt;
  logic [VSUM_W:0]   vsum_add;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign fire      = (state_r == S_E_OUT) && (!out_valid_r || out_ready);

  assign seg_nx = CW'(seg_r) + CW'(1);
  assign num63  = {prod_r[53:0], 9'b0};
  assign tsat   = (vsum_r == '0) || (num63[62:32] >= 31'(vsum_r));
  assign dlt    = t1_r - t0_r;
  assign sum67  = acc_r + prod_r[66:0];
  assign n68    = {sum67, 1'b0} + 68'(dlt);
  assign qlow   = div_quo[31:0];
  assign vsum_add = {1'b0, vsum_r} + (VSUM_W+1)'(in_velocity);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_L_M1: begin
        mul_a = MUL_W'(cnt_r);
        mul_b = MUL_W'(ds_r);
      end
      S_L_M2: begin
        mul_a = MUL_W'(cnt_r) + MUL_W'(1);
        mul_b = MUL_W'(MS_SCALE);
      end
      S_L_M3: begin
        mul_a = MUL_W'(z_r);
        mul_b = MUL_W'(prod_r[26:0]);
      end
      S_E_X: begin
        mul_a = MUL_W'(oidx_r);
        mul_b = MUL_W'(ts_r);
      end
      S_E_M0: begin
        mul_a = MUL_W'($signed(v0_r));
        mul_b = MUL_W'($signed({2'b0, t1_r}) - $signed({2'b0, x_r}));
      end
      S_E_M1: begin
        mul_a = MUL_W'($signed(v1_r));
        mul_b = MUL_W'($signed({2'b0, x_r}) - $signed({2'b0, t0_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    raddr        = '0;
    we           = 1'b0;
    wtime        = qlow;
    seg_inc      = 1'b0;
    res_we       = 1'b0;
    res_val      = nv_r;
    div_ctl      = '0;
    div_rem_init = '0;
    div_num      = '0;
    div_den      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation) begin
            state_nxt = S_E_X;
          end else if (cnt_r < CW'(MAX_SAMPLES)) begin
            state_nxt = S_L_M1;
          end
        end
      end
      S_L_M1: state_nxt = S_L_M2;
      S_L_M2: state_nxt = S_L_M3;
      S_L_M3: state_nxt = S_L_DIV;
      S_L_DIV: begin
        div_rem_init = DIVR_W'(num63[62:32]);
        div_num      = {num63[31:0], 36'b0};
        div_den      = DIVD_W'(vsum_r);
        if (tsat) begin
          we        = 1'b1;
          wtime     = TIME_MAX;
          state_nxt = S_IDLE;
        end else begin
          div_ctl.start = 1'b1;
          div_ctl.iters = ITERS_LOAD;
          state_nxt     = S_L_WAIT;
        end
      end
      S_L_WAIT: begin
        if (div_sts.done) begin
          we        = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_E_X: state_nxt = S_E_RD0;
      S_E_RD0: begin
        if (cnt_r == '0) begin
          res_we    = 1'b1;
          state_nxt = S_E_OUT;
        end else begin
          state_nxt = S_E_CHK0;
        end
      end
      S_E_CHK0: begin
        if (x_r < rt) begin
          res_we    = 1'b1;
          state_nxt = S_E_OUT;
        end else begin
          state_nxt = S_E_WALK;
        end
      end
      S_E_WALK: begin
        if (seg_nx < cnt_r) begin
          raddr     = AW'(seg_nx);
          state_nxt = S_E_WCHK;
        end else begin
          res_we    = 1'b1;
          state_nxt = S_E_OUT;
        end
      end
      S_E_WCHK: begin
        // advance while the next point still lies before the grid time
        if (rt < x_r) begin
          seg_inc   = 1'b1;
          state_nxt = S_E_WALK;
        end else begin
          state_nxt = S_E_RDA;
        end
      end
      S_E_RDA: begin
        raddr     = seg_r;
        state_nxt = S_E_RDB;
      end
      S_E_RDB: begin
        raddr     = AW'(seg_nx);
        state_nxt = S_E_CAPB;
      end
      S_E_CAPB: begin
        if (rt == t0_r) begin
          res_we    = 1'b1;
          res_val   = v0_r;
          state_nxt = S_E_OUT;
        end else begin
          state_nxt = S_E_M0;
        end
      end
      S_E_M0: state_nxt = S_E_M1;
      S_E_M1: state_nxt = S_E_M2;
      S_E_M2: begin
        // round half up: floor((2*sum + d) / (2*d)) on the magnitude
        div_ctl.start = 1'b1;
        div_ctl.iters = ITERS_EMIT;
        div_num       = n68[67] ? (~n68 + 68'(1)) : n68;
        div_den       = {dlt, 1'b0};
        state_nxt     = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (div_sts.done) begin
          res_we    = 1'b1;
          res_val   = !neg_r ? qlow : ((div_rem != '0) ? ~qlow : (~qlow + 32'd1));
          state_nxt = S_E_OUT;
        end
      end
      S_E_OUT: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration and trace control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r        <= '0;
      ds_r        <= 10'd1;
      ts_r        <= 16'd256;
      oc_r        <= 16'd1000;
      nv_r        <= '0;
      vsum_r      <= '0;
      cnt_r       <= '0;
      seg_r       <= '0;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_FIRST_DEPTH) fd_r <= cfg_data[15:0];
        if (cfg_index == CFG_DEPTH_STEP)  ds_r <= cfg_data[9:0];
        if (cfg_index == CFG_TIME_STEP)   ts_r <= cfg_data[15:0];
        if (cfg_index == CFG_OUT_COUNT)   oc_r <= cfg_data[15:0];
        if (cfg_index == CFG_NULL_VALUE)  nv_r <= cfg_data;
      end
      if (state_r == S_IDLE && accept && !in_operation && cnt_r < CW'(MAX_SAMPLES)) begin
        vsum_r <= vsum_add[VSUM_W] ? VSUM_MAX : vsum_add[VSUM_W-1:0];
      end
      if (we) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (seg_inc) begin
        seg_r <= AW'(seg_nx);
      end
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          vsum_r <= '0;
          cnt_r  <= '0;
          seg_r  <= '0;
          oidx_r <= '0;
        end else begin
          oidx_r <= oidx_r + 16'd1;
        end
      end
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r <= in_sample_value;
      last_r <= ({1'b0, oidx_r} + 17'd1) >= {1'b0, oc_r};
    end
    if (state_r == S_L_M2) z_r <= 27'(fd_r) + prod_r[26:0];
    if (state_r == S_E_RD0) x_r <= prod_r[31:0];
    if (state_r == S_E_RDB) begin
      t0_r <= rt;
      v0_r <= rv;
    end
    if (state_r == S_E_CAPB) begin
      t1_r <= rt;
      v1_r <= rv;
    end
    if (state_r == S_E_M1) acc_r <= prod_r[66:0];
    if (state_r == S_E_M2) neg_r <= n68[67];
    if (res_we) res_r <= res_val;
    if (fire) begin
      out_value_r <= res_r;
      out_index_r <= oidx_r;
      out_end_r   <= last_r;
    end
  end

  dttr_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_time_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (wtime),
    .raddr (raddr),
    .rdata (rt)
  );

  dttr_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_value_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (samp_r),
    .raddr (raddr),
    .rdata (rv)
  );

  dttr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .num_init (div_num),
    .den      (div_den),
    .sts      (div_sts),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_index     = out_index_r;
  assign out_trace_end = out_end_r;

endmodule

// ===== sv/dttr_checker.sv =====
// ----------------------------------------------------------------------------
// Depth-to-time resampler port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "depth_to_time_trace_resampler_top_macros.svh"

module dttr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [15:0] out_index
);

  // an emit word keeps the block busy after it is accepted
  `DTTR_ASSERT_NXT(a_emit_busy, in_valid && in_ready && in_operation, !in_ready, "emit word did not hold off input")

  // a result only appears when the block was busy with an emit
  `DTTR_ASSERT_NOW(a_result_source, $rose(out_valid), !$past(in_ready), "result appeared while idle")

  // hold a stalled result word
  `DTTR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_index), "stalled result word changed")

endmodule

bind depth_to_time_trace_resampler_top dttr_checker u_dttr_checker (.*);
